// ===== hw/rtl/tis_pkg.sv =====
// ----------------------------------------------------------------------------
// tis_pkg
// Shared types and fixed widths of the tetrahedron insphere pipeline.
// ----------------------------------------------------------------------------
package tis_pkg;

    // width of one coordinate field on the input channel
    localparam int IN_W  = 16;
    // width of one result field
    localparam int OUT_W = 32;
    // headroom for zero extension ahead of the coordinate mask
    localparam int EXT_W = 40;
    // quotient bits kept by the divider, one above the widest output
    localparam int QB    = 33;
    // faces, axes, coordinate fields
    localparam int NFACE = 4;
    localparam int NAXIS = 3;
    localparam int NPT   = 12;

    // saturation bounds of the outputs
    localparam logic [QB-1:0] RAD_MAX = {1'b0, {OUT_W{1'b1}}};
    localparam logic [QB-1:0] POS_MAX = {2'b00, {(OUT_W-1){1'b1}}};
    localparam logic [QB-1:0] NEG_MAX = {2'b01, {(OUT_W-1){1'b0}}};

    // pipeline advance and the valid bit of the beat entering a unit
    typedef struct packed {
        logic en;
        logic valid;
    } t_pipe_ctl;

endpackage

// ===== hw/rtl/tis_if.sv =====
// ----------------------------------------------------------------------------
// tis_if
// Valid/ready channels: vertex beats in, insphere beats out.
// ----------------------------------------------------------------------------
interface tis_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] p0_x, p0_y, p0_z;
    logic signed [15:0] p1_x, p1_y, p1_z;
    logic signed [15:0] p2_x, p2_y, p2_z;
    logic signed [15:0] p3_x, p3_y, p3_z;

    modport source (output valid, p0_x, p0_y, p0_z, p1_x, p1_y, p1_z,
                    p2_x, p2_y, p2_z, p3_x, p3_y, p3_z, input ready);
    modport sink   (input valid, p0_x, p0_y, p0_z, p1_x, p1_y, p1_z,
                    p2_x, p2_y, p2_z, p3_x, p3_y, p3_z, output ready);
endinterface

interface tis_out_if;
    logic               valid;
    logic               ready;
    logic               valid_res;
    logic signed [31:0] center_x, center_y, center_z;
    logic        [31:0] radius;

    modport source (output valid, valid_res, center_x, center_y, center_z, radius,
                    input ready);
    modport sink   (input valid, valid_res, center_x, center_y, center_z, radius,
                    output ready);
endinterface

// ===== hw/rtl/tetrahedron_insphere.sv =====
// ----------------------------------------------------------------------------
// tetrahedron_insphere
// Inscribed sphere of a tetrahedron: center and radius in fixed point.
//
//   port       dir   handshake     beat
//   i_pts      in    valid/ready   four vertices, twelve signed coordinates
//   o_res      out   valid/ready   valid_res, center x/y/z, radius
//   i_cfg_*    in    write enable  flat_limit, 32 bits
//
// One beat enters per cycle while o_res is not stalled. The stages are:
// 5 geometry stages, one stage per square root bit, 2 weighting
// stages, 34 divider stages and the output register.
// Synchronous active-low reset clears the valid bits and flat_limit.
// A stall on o_res freezes every stage at once; i_pts.ready is low only
// while a result is held and not taken.
// ----------------------------------------------------------------------------
module tetrahedron_insphere import tis_pkg::*; #(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    tis_in_if.sink       i_pts,
    tis_out_if.source    o_res,
    input  logic         i_cfg_we,
    input  logic [31:0]  i_cfg_wdata
);
    localparam int C     = COORD_BITS;
    localparam int D     = C + 1;
    localparam int X     = 2 * D + 1;
    localparam int V6_W  = 3 * D + 3;
    localparam int SS_W  = 2 * X + 2;
    localparam int R_W   = SS_W / 2;
    localparam int S_W   = R_W + 1 + C + 2;
    localparam int MW    = (V6_W > S_W - 1) ? V6_W : S_W - 1;
    localparam int NUM_W = MW + FRAC_BITS;
    localparam int WS_W  = R_W + 2;
    localparam int SD_W  = NPT * C + V6_W + 1;

    logic                 w_en;
    t_pipe_ctl            w_ctl_g, w_ctl_s, w_ctl_w, w_ctl_d;
    logic [31:0]          r_flat_limit;
    logic [IN_W-1:0]      w_raw [NPT];

    logic                 w_g_valid, w_g_flat;
    logic [V6_W-1:0]      w_g_v6;
    logic [SS_W-1:0]      w_g_sq [NFACE];
    logic signed [C-1:0]  w_g_p [NPT];
    logic [SD_W-1:0]      w_s_in, w_s_out;

    logic                 w_s_valid;
    logic [R_W-1:0]       w_root [NFACE];
    logic signed [C-1:0]  w_s_p [NPT];
    logic [V6_W-1:0]      w_s_v6;
    logic                 w_s_flat;

    logic                 w_w_valid;
    logic [NUM_W-1:0]     w_num [NFACE];
    logic [WS_W-1:0]      w_den;
    logic [3:0]           w_w_side;

    logic                 w_d_valid;
    logic [QB-1:0]        w_q [NFACE];
    logic [NFACE-1:0]     w_ovf;
    logic [3:0]           w_d_side;

    logic                 r_out_valid, r_valid_res;
    logic [OUT_W-1:0]     r_center [NAXIS], n_center [NAXIS];
    logic [OUT_W-1:0]     r_radius, n_radius;
    logic                 n_valid_res;

    // whole pipeline advances unless a held result is not taken
    assign w_en        = o_res.ready || !r_out_valid;
    assign i_pts.ready = w_en;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flat_limit <= '0;
        end else if (i_cfg_we) begin
            r_flat_limit <= i_cfg_wdata;
        end
    end

    assign w_raw = '{i_pts.p0_x, i_pts.p0_y, i_pts.p0_z, i_pts.p1_x, i_pts.p1_y, i_pts.p1_z,
                     i_pts.p2_x, i_pts.p2_y, i_pts.p2_z, i_pts.p3_x, i_pts.p3_y, i_pts.p3_z};

    assign w_ctl_g = '{en: w_en, valid: i_pts.valid};
    assign w_ctl_s = '{en: w_en, valid: w_g_valid};
    assign w_ctl_w = '{en: w_en, valid: w_s_valid};
    assign w_ctl_d = '{en: w_en, valid: w_w_valid};

    tis_geom #(.COORD_BITS(C)) u_geom (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (w_ctl_g),
        .i_raw        (w_raw),
        .i_flat_limit (r_flat_limit),
        .o_valid      (w_g_valid),
        .o_flat       (w_g_flat),
        .o_v6         (w_g_v6),
        .o_sq         (w_g_sq),
        .o_p          (w_g_p)
    );

    // vertices, six-volume and flat flag ride along the square root stages
    always_comb begin
        for (int j = 0; j < NPT; j++) begin
            w_s_in[j*C +: C] = w_g_p[j];
            w_s_p[j]         = w_s_out[j*C +: C];
        end
        w_s_in[NPT*C +: V6_W] = w_g_v6;
        w_s_in[SD_W-1]        = w_g_flat;
        w_s_v6                = w_s_out[NPT*C +: V6_W];
        w_s_flat              = w_s_out[SD_W-1];
    end

    tis_sqrt #(.SS_W(SS_W), .SIDE_W(SD_W)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl_s),
        .i_sq    (w_g_sq),
        .i_side  (w_s_in),
        .o_valid (w_s_valid),
        .o_root  (w_root),
        .o_side  (w_s_out)
    );

    tis_wsum #(.COORD_BITS(C), .R_W(R_W), .V6_W(V6_W), .NUM_W(NUM_W)) u_wsum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl_w),
        .i_w     (w_root),
        .i_p     (w_s_p),
        .i_v6    (w_s_v6),
        .i_flat  (w_s_flat),
        .o_valid (w_w_valid),
        .o_num   (w_num),
        .o_den   (w_den),
        .o_side  (w_w_side)
    );

    tis_div #(.NUM_W(NUM_W), .DEN_W(WS_W), .SIDE_W(4)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl_d),
        .i_num   (w_num),
        .i_den   (w_den),
        .i_side  (w_w_side),
        .o_valid (w_d_valid),
        .o_q     (w_q),
        .o_ovf   (w_ovf),
        .o_side  (w_d_side)
    );

    // saturation, sign and coplanar zeroing
    always_comb begin
        logic [QB-1:0] v_m;
        n_valid_res = !w_d_side[3];
        n_radius    = (w_ovf[0] || w_q[0] > RAD_MAX) ? OUT_W'(RAD_MAX) : w_q[0][OUT_W-1:0];
        for (int k = 0; k < NAXIS; k++) begin
            if (w_d_side[k]) begin
                v_m         = (w_ovf[k+1] || w_q[k+1] > NEG_MAX) ? NEG_MAX : w_q[k+1];
                n_center[k] = OUT_W'(-v_m);
            end else begin
                v_m         = (w_ovf[k+1] || w_q[k+1] > POS_MAX) ? POS_MAX : w_q[k+1];
                n_center[k] = v_m[OUT_W-1:0];
            end
        end
        if (w_d_side[3]) begin
            n_radius = '0;
            n_center = '{default: '0};
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_valid_res <= n_valid_res;
            r_radius    <= n_radius;
            r_center    <= n_center;
        end
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.valid_res = r_valid_res;
    assign o_res.radius    = r_radius;
    assign o_res.center_x  = r_center[0];
    assign o_res.center_y  = r_center[1];
    assign o_res.center_z  = r_center[2];

endmodule

// ===== hw/rtl/tis_geom.sv =====
// ----------------------------------------------------------------------------
// tis_geom
// Five stages: edge vectors, cross products, six-volume and squared face norms.
// ----------------------------------------------------------------------------
module tis_geom import tis_pkg::*; #(
    parameter int COORD_BITS = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_pipe_ctl                  i_ctl,
    input  logic [IN_W-1:0]            i_raw [NPT],
    input  logic [31:0]                i_flat_limit,
    output logic                       o_valid,
    output logic                       o_flat,
    output logic [3*COORD_BITS+5:0]    o_v6,
    output logic [4*COORD_BITS+7:0]    o_sq [NFACE],
    output logic signed [COORD_BITS-1:0] o_p [NPT]
);
    localparam int C    = COORD_BITS;
    localparam int D    = C + 1;
    localparam int P    = 2 * D;
    localparam int X    = P + 1;
    localparam int T    = D + X;
    localparam int V6_W = T + 2;
    localparam int SS_W = 2 * X + 2;
    localparam int LW   = (V6_W > 32) ? V6_W : 32;

    // edge vectors: p1-p0, p2-p0, p3-p0, p2-p1, p3-p1
    localparam int DA [5] = '{1, 2, 3, 2, 3};
    localparam int DB [5] = '{0, 0, 0, 1, 1};
    // edge pair spanning the face opposite each vertex
    localparam int FU [4] = '{3, 1, 0, 0};
    localparam int FV [4] = '{4, 2, 2, 1};

    logic [4:0]                 r_valid;
    logic signed [C-1:0]        r1_p [NPT], r2_p [NPT], r3_p [NPT], r4_p [NPT], r5_p [NPT];
    logic signed [C-1:0]        n1_p [NPT];
    logic signed [D-1:0]        r1_d [5][NAXIS], n1_d [5][NAXIS];
    logic signed [D-1:0]        r2_e [NAXIS], r3_e [NAXIS];
    logic signed [P-1:0]        r2_m [NFACE][NAXIS][2], n2_m [NFACE][NAXIS][2];
    logic signed [X-1:0]        r3_c [NFACE][NAXIS], n3_c [NFACE][NAXIS];
    logic signed [T-1:0]        r4_t [NAXIS], n4_t [NAXIS];
    logic        [2*X-1:0]      r4_q [NFACE][NAXIS], n4_q [NFACE][NAXIS];
    logic        [V6_W-1:0]     r5_v6, n5_v6;
    logic                       r5_flat, n5_flat;
    logic        [SS_W-1:0]     r5_sq [NFACE], n5_sq [NFACE];

    // stage 1: mask and sign-extend coordinates, edge vectors
    always_comb begin
        logic [EXT_W-1:0] v_ext;
        for (int j = 0; j < NPT; j++) begin
            v_ext   = EXT_W'(i_raw[j]);
            n1_p[j] = v_ext[C-1:0];
        end
        for (int e = 0; e < 5; e++) begin
            for (int k = 0; k < NAXIS; k++) begin
                n1_d[e][k] = $signed({n1_p[3*DA[e]+k][C-1], n1_p[3*DA[e]+k]})
                           - $signed({n1_p[3*DB[e]+k][C-1], n1_p[3*DB[e]+k]});
            end
        end
    end

    // stage 2: cross product partial products
    always_comb begin
        for (int f = 0; f < NFACE; f++) begin
            for (int k = 0; k < NAXIS; k++) begin
                n2_m[f][k][0] = r1_d[FU[f]][(k+1)%3] * r1_d[FV[f]][(k+2)%3];
                n2_m[f][k][1] = r1_d[FU[f]][(k+2)%3] * r1_d[FV[f]][(k+1)%3];
            end
        end
    end

    // stage 3: cross product components
    always_comb begin
        for (int f = 0; f < NFACE; f++) begin
            for (int k = 0; k < NAXIS; k++) begin
                n3_c[f][k] = X'(r2_m[f][k][0]) - X'(r2_m[f][k][1]);
            end
        end
    end

    // stage 4: triple product terms and squared components
    always_comb begin
        logic signed [2*X-1:0] v_sq;
        for (int k = 0; k < NAXIS; k++) begin
            n4_t[k] = r3_e[k] * r3_c[1][k];
        end
        for (int f = 0; f < NFACE; f++) begin
            for (int k = 0; k < NAXIS; k++) begin
                v_sq       = r3_c[f][k] * r3_c[f][k];
                n4_q[f][k] = v_sq;
            end
        end
    end

    // stage 5: six-volume magnitude, flatness test, squared face norms
    always_comb begin
        logic signed [T+1:0] v_sum;
        v_sum   = (T+2)'(r4_t[0]) + (T+2)'(r4_t[1]) + (T+2)'(r4_t[2]);
        n5_v6   = v_sum[T+1] ? V6_W'(-v_sum) : V6_W'(v_sum);
        n5_flat = LW'(i_flat_limit) >= LW'(n5_v6);
        for (int f = 0; f < NFACE; f++) begin
            n5_sq[f] = SS_W'(r4_q[f][0]) + SS_W'(r4_q[f][1]) + SS_W'(r4_q[f][2]);
        end
    end

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_ctl.en) begin
            r_valid <= {r_valid[3:0], i_ctl.valid};
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r1_p    <= n1_p;
            r2_p    <= r1_p;
            r3_p    <= r2_p;
            r4_p    <= r3_p;
            r5_p    <= r4_p;
            r1_d    <= n1_d;
            r2_e    <= r1_d[0];
            r3_e    <= r2_e;
            r2_m    <= n2_m;
            r3_c    <= n3_c;
            r4_t    <= n4_t;
            r4_q    <= n4_q;
            r5_v6   <= n5_v6;
            r5_flat <= n5_flat;
            r5_sq   <= n5_sq;
        end
    end

    assign o_valid = r_valid[4];
    assign o_flat  = r5_flat;
    assign o_v6    = r5_v6;
    assign o_sq    = r5_sq;
    assign o_p     = r5_p;

endmodule

// ===== hw/rtl/tis_sqrt.sv =====
// ----------------------------------------------------------------------------
// tis_sqrt
// Four truncating integer square roots, one root bit per pipeline stage.
// ----------------------------------------------------------------------------
module tis_sqrt import tis_pkg::*; #(
    parameter int SS_W   = 72,
    parameter int SIDE_W = 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_pipe_ctl           i_ctl,
    input  logic [SS_W-1:0]     i_sq [NFACE],
    input  logic [SIDE_W-1:0]   i_side,
    output logic                o_valid,
    output logic [SS_W/2-1:0]   o_root [NFACE],
    output logic [SIDE_W-1:0]   o_side
);
    localparam int R_W = SS_W / 2;
    localparam int RM  = R_W + 2;

    logic [R_W-1:0]     r_valid;
    logic [SS_W-1:0]    r_n    [R_W][NFACE], a_n    [R_W][NFACE], n_n    [R_W][NFACE];
    logic [R_W-1:0]     r_root [R_W][NFACE], a_root [R_W][NFACE], n_root [R_W][NFACE];
    logic [RM-1:0]      r_rem  [R_W][NFACE], a_rem  [R_W][NFACE], n_rem  [R_W][NFACE];
    logic [SIDE_W-1:0]  r_side [R_W],        a_side [R_W];

    // stage inputs: ports for the first stage, previous stage otherwise
    for (genvar s = 0; s < R_W; s++) begin : g_src
        if (s == 0) begin : g_first
            assign a_n[s]    = i_sq;
            assign a_root[s] = '{default: '0};
            assign a_rem[s]  = '{default: '0};
            assign a_side[s] = i_side;
        end else begin : g_next
            assign a_n[s]    = r_n[s-1];
            assign a_root[s] = r_root[s-1];
            assign a_rem[s]  = r_rem[s-1];
            assign a_side[s] = r_side[s-1];
        end
    end

    // one root bit per stage: bring down two bits, try root*4+1
    always_comb begin
        logic [RM-1:0] v_rem;
        logic [RM-1:0] v_try;
        for (int s = 0; s < R_W; s++) begin
            for (int f = 0; f < NFACE; f++) begin
                v_rem = {a_rem[s][f][RM-3:0], a_n[s][f][SS_W-1 -: 2]};
                v_try = {a_root[s][f], 2'b01};
                n_n[s][f] = {a_n[s][f][SS_W-3:0], 2'b00};
                if (v_rem >= v_try) begin
                    n_rem[s][f]  = v_rem - v_try;
                    n_root[s][f] = {a_root[s][f][R_W-2:0], 1'b1};
                end else begin
                    n_rem[s][f]  = v_rem;
                    n_root[s][f] = {a_root[s][f][R_W-2:0], 1'b0};
                end
            end
        end
    end

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_ctl.en) begin
            r_valid <= {r_valid[R_W-2:0], i_ctl.valid};
        end
    end

    // stage registers
    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_n    <= n_n;
            r_root <= n_root;
            r_rem  <= n_rem;
            r_side <= a_side;
        end
    end

    assign o_valid = r_valid[R_W-1];
    assign o_root  = r_root[R_W-1];
    assign o_side  = r_side[R_W-1];

endmodule

// ===== hw/rtl/tis_wsum.sv =====
// ----------------------------------------------------------------------------
// tis_wsum
// Two stages: weight sum and weighted vertices, then per-axis sign and magnitude.
// ----------------------------------------------------------------------------
module tis_wsum import tis_pkg::*; #(
    parameter int COORD_BITS = 16,
    parameter int R_W        = 36,
    parameter int V6_W       = 54,
    parameter int NUM_W      = 70
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_pipe_ctl                     i_ctl,
    input  logic [R_W-1:0]                i_w [NFACE],
    input  logic signed [COORD_BITS-1:0]  i_p [NPT],
    input  logic [V6_W-1:0]               i_v6,
    input  logic                          i_flat,
    output logic                          o_valid,
    output logic [NUM_W-1:0]              o_num [NFACE],
    output logic [R_W+1:0]                o_den,
    output logic [3:0]                    o_side
);
    localparam int C    = COORD_BITS;
    localparam int PR_W = R_W + 1 + C;
    localparam int S_W  = PR_W + 2;
    localparam int MW   = NUM_W - (NUM_W - ((V6_W > S_W - 1) ? V6_W : S_W - 1));
    localparam int FB   = NUM_W - MW;
    localparam int WS_W = R_W + 2;

    logic [1:0]               r_valid;
    logic signed [PR_W-1:0]   r_pr [NAXIS][NFACE], n_pr [NAXIS][NFACE];
    logic [WS_W-1:0]          r_ws, n_ws, r2_ws;
    logic [V6_W-1:0]          r_v6;
    logic                     r_flat;
    logic [MW-1:0]            r2_mag [NFACE], n2_mag [NFACE];
    logic [2:0]               n2_neg, r2_neg;
    logic                     n2_zero, r2_zero;

    // stage 1: weight sum and weight times coordinate
    always_comb begin
        n_ws = WS_W'(i_w[0]) + WS_W'(i_w[1]) + WS_W'(i_w[2]) + WS_W'(i_w[3]);
        for (int k = 0; k < NAXIS; k++) begin
            for (int i = 0; i < NFACE; i++) begin
                n_pr[k][i] = $signed({1'b0, i_w[i]}) * i_p[3*i+k];
            end
        end
    end

    // stage 2: per-axis sums split into sign and magnitude
    always_comb begin
        logic signed [S_W-1:0] v_s;
        n2_mag[0] = MW'(r_v6);
        for (int k = 0; k < NAXIS; k++) begin
            v_s = S_W'(r_pr[k][0]) + S_W'(r_pr[k][1]) + S_W'(r_pr[k][2]) + S_W'(r_pr[k][3]);
            n2_neg[k]   = v_s[S_W-1];
            n2_mag[k+1] = v_s[S_W-1] ? MW'(-v_s) : MW'(v_s);
        end
        n2_zero = r_flat || (r_ws == '0);
    end

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_ctl.en) begin
            r_valid <= {r_valid[0], i_ctl.valid};
        end
    end

    // stage registers
    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_pr    <= n_pr;
            r_ws    <= n_ws;
            r_v6    <= i_v6;
            r_flat  <= i_flat;
            r2_mag  <= n2_mag;
            r2_neg  <= n2_neg;
            r2_zero <= n2_zero;
            r2_ws   <= r_ws;
        end
    end

    // numerators carry the fraction bits below the magnitude
    always_comb begin
        for (int i = 0; i < NFACE; i++) begin
            o_num[i] = {r2_mag[i], {FB{1'b0}}};
        end
    end

    assign o_valid = r_valid[1];
    assign o_den   = r2_ws;
    assign o_side  = {r2_zero, r2_neg};

endmodule

// ===== hw/rtl/tis_div.sv =====
// ----------------------------------------------------------------------------
// tis_div
// Four restoring divisions by a shared divisor, one quotient bit per stage,
// with an overflow flag for quotients beyond the kept bits.
// ----------------------------------------------------------------------------
module tis_div import tis_pkg::*; #(
    parameter int NUM_W  = 70,
    parameter int DEN_W  = 38,
    parameter int SIDE_W = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_pipe_ctl           i_ctl,
    input  logic [NUM_W-1:0]    i_num [NFACE],
    input  logic [DEN_W-1:0]    i_den,
    input  logic [SIDE_W-1:0]   i_side,
    output logic                o_valid,
    output logic [QB-1:0]       o_q   [NFACE],
    output logic [NFACE-1:0]    o_ovf,
    output logic [SIDE_W-1:0]   o_side
);
    localparam int HI_W = NUM_W - QB;
    localparam int HW   = (HI_W > DEN_W) ? HI_W : DEN_W;

    logic [QB:0]          r_valid;
    logic [DEN_W-1:0]     r0_rem [NFACE], n0_rem [NFACE];
    logic [QB-1:0]        r0_lo  [NFACE];
    logic [NFACE-1:0]     r0_ovf, n0_ovf;
    logic [DEN_W-1:0]     r0_den;
    logic [SIDE_W-1:0]    r0_side;

    logic [DEN_W-1:0]     r_rem [QB][NFACE], a_rem [QB][NFACE], n_rem [QB][NFACE];
    logic [QB-1:0]        r_lo  [QB][NFACE], a_lo  [QB][NFACE], n_lo  [QB][NFACE];
    logic [QB-1:0]        r_q   [QB][NFACE], a_q   [QB][NFACE], n_q   [QB][NFACE];
    logic [NFACE-1:0]     r_ovf [QB], a_ovf [QB];
    logic [DEN_W-1:0]     r_den [QB], a_den [QB];
    logic [SIDE_W-1:0]    r_side [QB], a_side [QB];

    // entry stage: overflow test on the high part, initial remainder
    always_comb begin
        logic [HW-1:0] v_hi;
        for (int f = 0; f < NFACE; f++) begin
            v_hi       = HW'(i_num[f][NUM_W-1:QB]);
            n0_ovf[f]  = v_hi >= HW'(i_den);
            n0_rem[f]  = v_hi[DEN_W-1:0];
        end
    end

    // stage inputs
    for (genvar s = 0; s < QB; s++) begin : g_src
        if (s == 0) begin : g_first
            assign a_rem[s]  = r0_rem;
            assign a_lo[s]   = r0_lo;
            assign a_q[s]    = '{default: '0};
            assign a_ovf[s]  = r0_ovf;
            assign a_den[s]  = r0_den;
            assign a_side[s] = r0_side;
        end else begin : g_next
            assign a_rem[s]  = r_rem[s-1];
            assign a_lo[s]   = r_lo[s-1];
            assign a_q[s]    = r_q[s-1];
            assign a_ovf[s]  = r_ovf[s-1];
            assign a_den[s]  = r_den[s-1];
            assign a_side[s] = r_side[s-1];
        end
    end

    // one quotient bit per stage
    always_comb begin
        logic [DEN_W:0] v_rem;
        for (int s = 0; s < QB; s++) begin
            for (int f = 0; f < NFACE; f++) begin
                v_rem      = {a_rem[s][f], a_lo[s][f][QB-1]};
                n_lo[s][f] = {a_lo[s][f][QB-2:0], 1'b0};
                if (v_rem >= {1'b0, a_den[s]}) begin
                    n_rem[s][f] = DEN_W'(v_rem - {1'b0, a_den[s]});
                    n_q[s][f]   = {a_q[s][f][QB-2:0], 1'b1};
                end else begin
                    n_rem[s][f] = v_rem[DEN_W-1:0];
                    n_q[s][f]   = {a_q[s][f][QB-2:0], 1'b0};
                end
            end
        end
    end

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_ctl.en) begin
            r_valid <= {r_valid[QB-1:0], i_ctl.valid};
        end
    end

    // stage registers
    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r0_rem  <= n0_rem;
            r0_ovf  <= n0_ovf;
            r0_den  <= i_den;
            r0_side <= i_side;
            for (int f = 0; f < NFACE; f++) begin
                r0_lo[f] <= i_num[f][QB-1:0];
            end
            r_rem  <= n_rem;
            r_lo   <= n_lo;
            r_q    <= n_q;
            r_ovf  <= a_ovf;
            r_den  <= a_den;
            r_side <= a_side;
        end
    end

    assign o_valid = r_valid[QB];
    assign o_q     = r_q[QB-1];
    assign o_ovf   = r_ovf[QB-1];
    assign o_side  = r_side[QB-1];

endmodule

// ===== hw/rtl/tis_chk.sv =====
// ----------------------------------------------------------------------------
// tis_chk
// Port-level checks of the insphere pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module tis_chk (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_ready,
    input  logic         i_out_valid,
    input  logic         i_out_ready,
    input  logic         i_valid_res,
    input  logic [31:0]  i_center_x,
    input  logic [31:0]  i_center_y,
    input  logic [31:0]  i_center_z,
    input  logic [31:0]  i_radius
);

    // a held result keeps its radius, center_x and valid_res
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_radius)
            && $stable(i_center_x) && $stable(i_valid_res))
        else $error("held result changed");

    // input side stalls only behind an untaken result
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_ready == (i_out_ready || !i_out_valid))
        else $error("input ready does not follow output side");

    // coplanar beats carry zeros
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_valid_res |-> i_radius == 32'd0 && i_center_x == 32'd0
            && i_center_y == 32'd0 && i_center_z == 32'd0)
        else $error("coplanar result not zero");

    // pipeline empty right after reset
    a_rst: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind tetrahedron_insphere tis_chk u_tis_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_pts.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_valid_res (o_res.valid_res),
    .i_center_x  (o_res.center_x),
    .i_center_y  (o_res.center_y),
    .i_center_z  (o_res.center_z),
    .i_radius    (o_res.radius)
);

// ===== verif/tis_tb_if.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tis_tb_if
// The testbench drives the vertex and insphere channels through the design's
// own tis_in_if and tis_out_if interfaces; nothing is declared here.
// ----------------------------------------------------------------------------

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Streams tetrahedra through the insphere pipeline with random gaps and stalls
// on both channels and checks every result beat against a fixed-point model.
// ----------------------------------------------------------------------------
module testbench;
    import tis_pkg::*;

    typedef struct packed {
        logic               ok;
        logic signed [31:0] cx, cy, cz;
        logic        [31:0] rad;
    } sphere_t;

    typedef logic signed [15:0] pts_t [12];

    // expected spheres in arrival order, with the insphere arithmetic
    class sphere_board;
        sphere_t     pending [$];
        int          errors;
        logic [31:0] limit;

        function automatic logic [63:0] root(logic [127:0] n);
            logic [63:0] r, c;
            r = 0;
            for (int b = 63; b >= 0; b--) begin
                c = r | (64'd1 << b);
                if ({64'd0, c} * {64'd0, c} <= n) r = c;
            end
            return r;
        endfunction

        function automatic logic [63:0] face_w(logic signed [63:0] ax, ay, az,
                                               bx, by, bz, ox, oy, oz);
            logic signed [63:0] ux, uy, uz, vx, vy, vz, c0, c1, c2;
            logic signed [127:0] s;
            ux = ax - ox; uy = ay - oy; uz = az - oz;
            vx = bx - ox; vy = by - oy; vz = bz - oz;
            c0 = uy * vz - uz * vy;
            c1 = uz * vx - ux * vz;
            c2 = ux * vy - uy * vx;
            s = 128'(c0) * 128'(c0) + 128'(c1) * 128'(c1) + 128'(c2) * 128'(c2);
            return root(s);
        endfunction

        function automatic sphere_t compute(pts_t p);
            logic signed [63:0] q [4][3];
            logic signed [63:0] ux, uy, uz, vx, vy, vz, wx, wy, wz;
            logic signed [127:0] t, s;
            logic [127:0] v6, quo;
            logic [63:0] w [4];
            logic [63:0] wsum;
            logic neg;
            sphere_t r;
            for (int i = 0; i < 4; i++)
                for (int k = 0; k < 3; k++) q[i][k] = 64'(p[i * 3 + k]);
            r = '0;
            ux = q[1][0] - q[0][0]; uy = q[1][1] - q[0][1]; uz = q[1][2] - q[0][2];
            vx = q[2][0] - q[0][0]; vy = q[2][1] - q[0][1]; vz = q[2][2] - q[0][2];
            wx = q[3][0] - q[0][0]; wy = q[3][1] - q[0][1]; wz = q[3][2] - q[0][2];
            t = 128'(ux) * 128'(vy * wz - vz * wy) + 128'(uy) * 128'(vz * wx - vx * wz)
                + 128'(uz) * 128'(vx * wy - vy * wx);
            v6 = t < 0 ? -t : t;
            if (v6 <= {96'd0, limit}) return r;
            w[0] = face_w(q[2][0], q[2][1], q[2][2], q[3][0], q[3][1], q[3][2],
                          q[1][0], q[1][1], q[1][2]);
            w[1] = face_w(q[2][0], q[2][1], q[2][2], q[3][0], q[3][1], q[3][2],
                          q[0][0], q[0][1], q[0][2]);
            w[2] = face_w(q[1][0], q[1][1], q[1][2], q[3][0], q[3][1], q[3][2],
                          q[0][0], q[0][1], q[0][2]);
            w[3] = face_w(q[1][0], q[1][1], q[1][2], q[2][0], q[2][1], q[2][2],
                          q[0][0], q[0][1], q[0][2]);
            wsum = w[0] + w[1] + w[2] + w[3];
            if (wsum == 0) return r;
            r.ok = 1'b1;
            quo = (v6 << 16) / {64'd0, wsum};
            r.rad = quo > 128'hFFFF_FFFF ? 32'hFFFF_FFFF : quo[31:0];
            for (int k = 0; k < 3; k++) begin
                logic [31:0] m;
                s = 0;
                for (int i = 0; i < 4; i++) s += 128'(signed'({1'b0, w[i]})) * 128'(q[i][k]);
                neg = s < 0;
                if (neg) s = -s;
                quo = (128'(s) << 16) / {64'd0, wsum};
                if (neg) begin
                    m = quo > 128'h8000_0000 ? 32'h8000_0000 : quo[31:0];
                    m = -m;
                end else begin
                    m = quo > 128'h7FFF_FFFF ? 32'h7FFF_FFFF : quo[31:0];
                end
                if (k == 0) r.cx = m;
                else if (k == 1) r.cy = m;
                else r.cz = m;
            end
            return r;
        endfunction

        function void note_input(pts_t p);
            pending.push_back(compute(p));
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            $display("mismatch %s: got %h want %h", what, got, want);
            errors++;
        endtask

        task check_result(sphere_t got);
            sphere_t e;
            if (pending.size() == 0) begin
                report("unexpected beat", got.rad, 0);
                return;
            end
            e = pending.pop_front();
            if (got.ok !== e.ok) report("valid_res", got.ok, e.ok);
            if (got.cx !== e.cx) report("center_x", got.cx, e.cx);
            if (got.cy !== e.cy) report("center_y", got.cy, e.cy);
            if (got.cz !== e.cz) report("center_z", got.cz, e.cz);
            if (got.rad !== e.rad) report("radius", got.rad, e.rad);
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [31:0] i_cfg_wdata;
    tis_in_if    pts_if ();
    tis_out_if   res_if ();
    sphere_board board;
    int          idle_cycles;
    logic        stall_free;

    tetrahedron_insphere dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pts       (pts_if.sink),
        .o_res       (res_if.source),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
        return $urandom_range(0, 9) < 6 ? 0 : $urandom_range(1, 3);
    endfunction

    // result side: random stalls, check each accepted beat
    initial begin
        int hold;
        res_if.ready = 1'b0;
        board = new();
        @(posedge i_clk iff i_rst_n);
        forever begin
            hold = stall_free ? 0 : gap_len();
            if (hold > 0) begin
                res_if.ready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end
            res_if.ready <= 1'b1;
            @(posedge i_clk);
            if (res_if.valid && res_if.ready)
                board.check_result({res_if.valid_res, res_if.center_x, res_if.center_y,
                                    res_if.center_z, res_if.radius});
        end
    end

    // watchdog on cycles with no beat on either side
    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((pts_if.valid && pts_if.ready) || (res_if.valid && res_if.ready))
                idle_cycles = 0;
            else if (++idle_cycles >= 5000) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // one vertex beat, held until accepted
    task send_tet(pts_t p);
        pts_if.valid <= 1'b1;
        {pts_if.p0_x, pts_if.p0_y, pts_if.p0_z, pts_if.p1_x, pts_if.p1_y, pts_if.p1_z,
         pts_if.p2_x, pts_if.p2_y, pts_if.p2_z, pts_if.p3_x, pts_if.p3_y, pts_if.p3_z}
            <= {p[0], p[1], p[2], p[3], p[4], p[5], p[6], p[7], p[8], p[9], p[10], p[11]};
        @(posedge i_clk);
        while (!pts_if.ready) @(posedge i_clk);
        board.note_input(p);
    endtask

    task send_gap();
        int g;
        g = stall_free ? 0 : gap_len();
        if (g > 0) begin
            pts_if.valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    task drain();
        pts_if.valid <= 1'b0;
        @(posedge i_clk);
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task set_limit(logic [31:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        board.limit = v;
    endtask

    // random tetrahedron: small, medium or full range, sometimes flat or degenerate
    function automatic pts_t rand_tet();
        pts_t p;
        int mode, span;
        mode = $urandom_range(0, 9);
        span = mode < 4 ? 100 : (mode < 7 ? 3000 : 32767);
        for (int i = 0; i < 12; i++) p[i] = $urandom_range(0, 2 * span) - span;
        if (mode == 7) for (int i = 0; i < 4; i++) p[i * 3 + 2] = p[2];
        if (mode == 8) for (int k = 0; k < 3; k++) p[9 + k] = p[k];
        if (mode == 9) for (int i = 0; i < 12; i++) p[i] = $urandom();
        return p;
    endfunction

    initial begin
        pts_t p;
        logic [31:0] lims [4];
        lims = '{32'd0, 32'hFFFF_FFFF, 32'd1000, 32'd5};
        i_rst_n = 1'b0; i_cfg_we = 1'b0; i_cfg_wdata = '0; stall_free = 1'b0;
        pts_if.valid = 1'b0;
        {pts_if.p0_x, pts_if.p0_y, pts_if.p0_z, pts_if.p1_x, pts_if.p1_y, pts_if.p1_z,
         pts_if.p2_x, pts_if.p2_y, pts_if.p2_z, pts_if.p3_x, pts_if.p3_y, pts_if.p3_z} = '0;
        wait (board != null);
        board.limit = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: unit tetrahedron, coplanar, coincident, corners of the range
        p = '{0, 0, 0, 1, 0, 0, 0, 1, 0, 0, 0, 1};                 send_tet(p);
        p = '{0, 0, 0, 5, 0, 0, 0, 5, 0, 3, 3, 0};                 send_tet(p);
        p = '{7, 7, 7, 7, 7, 7, 7, 7, 7, 7, 7, 7};                 send_tet(p);
        p = '{-32768, -32768, -32768, 32767, -32768, -32768,
              -32768, 32767, -32768, -32768, -32768, 32767};        send_tet(p);
        p = '{32767, 32767, 32767, -32768, 32767, 32767,
              32767, -32768, 32767, 32767, 32767, -32768};          send_tet(p);
        p = '{-1, -1, -1, 0, -1, -1, -1, 0, -1, -1, -1, 0};         send_tet(p);
        p = '{-32768, 0, 0, 32767, 0, 0, 0, 32767, 0, 0, 0, -32768}; send_tet(p);
        p = '{32767, 32767, 32767, 32766, 32767, 32767,
              32767, 32766, 32767, 32767, 32767, 32766};            send_tet(p);
        p = '{0, 0, 0, 1, 0, 0, 0, 1, 0, 1, 1, 0};                 send_tet(p);
        drain();

        // random phases at several limits, the first with no gaps at all
        for (int ph = 0; ph < 4; ph++) begin
            set_limit(lims[ph]);
            stall_free = (ph == 0);
            for (int n = 0; n < 285; n++) begin
                send_tet(rand_tet());
                send_gap();
                // hold off until the pipeline is empty
                if (n == 150) begin
                    pts_if.valid <= 1'b0;
                    @(posedge i_clk);
                    while (board.pending.size() != 0) @(posedge i_clk);
                end
            end
            drain();
        end

        if (board.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

// ===== sim.f =====
hw/rtl/tis_pkg.sv
hw/rtl/tis_if.sv
hw/rtl/tis_geom.sv
hw/rtl/tis_sqrt.sv
hw/rtl/tis_wsum.sv
hw/rtl/tis_div.sv
hw/rtl/tetrahedron_insphere.sv
hw/rtl/tis_chk.sv
verif/tis_tb_if.sv
verif/testbench.sv
